[rtl/core/ple_pkg.sv]
// Shared types and codes for the positional list engine.
package ple_pkg;

  localparam int unsigned POS_W = 7;
  localparam int unsigned VAL_W = 32;

  typedef enum logic [1:0] {
    K_INSERT = 2'd0,
    K_ERASE  = 2'd1,
    K_GET    = 2'd2,
    K_FIND   = 2'd3
  } kind_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_RANGE = 2'd2,
    ST_MISS  = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_LOOK,
    S_DONE
  } state_t;

  typedef enum logic [1:0] {
    CO_HOLD,
    CO_INSERT,
    CO_ERASE
  } cell_op_t;

  // Control broadcast to every cell of the chain.
  typedef struct packed {
    cell_op_t op;
    logic     find;
  } cell_ctl_t;

  typedef struct packed {
    kind_t              kind;
    logic [POS_W-1:0]   position;
    logic [VAL_W-1:0]   value;
  } req_t;

  typedef struct packed {
    status_t            status;
    logic [VAL_W-1:0]   item;
    logic [POS_W-1:0]   found_at;
    logic [POS_W-1:0]   count;
  } rsp_t;

endpackage

[rtl/core/ple_cell.sv]
// One list slot: holds an entry, shifts it to or from its neighbours and flags a hit.
module ple_cell #(
  parameter int unsigned IDX       = 0,
  parameter int unsigned ITEM_BITS = 32,
  parameter int unsigned CW        = 8
) (
  input  logic                  clk,
  input  logic                  rst,
  input  ple_pkg::cell_ctl_t    ctl,
  input  logic [CW-1:0]         pm1,
  input  logic [CW-1:0]         fill_w,
  input  logic [ITEM_BITS-1:0]  key,
  input  logic [ITEM_BITS-1:0]  left,
  input  logic [ITEM_BITS-1:0]  right,
  output logic [ITEM_BITS-1:0]  entry,
  output logic                  hit
);
  import ple_pkg::*;

  localparam logic [CW-1:0] ME = CW'(IDX);

  logic [ITEM_BITS-1:0] entry_next;

  always_comb begin
    entry_next = entry;
    case (ctl.op)
      CO_INSERT: begin
        if (ME == pm1) begin
          entry_next = key;
        end else if (ME > pm1 && ME <= fill_w) begin
          entry_next = left;
        end
      end
      CO_ERASE: begin
        if (ME >= pm1 && (ME + CW'(1)) < fill_w) begin
          entry_next = right;
        end
      end
      default: entry_next = entry;
    endcase
  end

  // A find looks for equal live entries; get and erase select by position.
  assign hit = ctl.find ? ((entry == key) && (ME < fill_w)) : (ME == pm1);

  always_ff @(posedge clk) begin
    if (rst) begin
      entry <= '0;
    end else begin
      entry <= entry_next;
    end
  end

endmodule

[rtl/core/ple_tree.sv]
// Registered priority tree that returns the lowest-numbered hit with its data.
module ple_tree #(
  parameter int unsigned N  = 64,
  parameter int unsigned DW = 32
) (
  input  logic                          clk,
  input  logic                          hit  [N],
  input  logic [DW-1:0]                 data [N],
  output logic                          root_hit,
  output logic [$clog2(N)-1:0]          root_idx,
  output logic [DW-1:0]                 root_data
);

  localparam int unsigned LV = $clog2(N);
  localparam int unsigned P  = 1 << LV;

  logic          hit_q [LV+1][P];
  logic [LV-1:0] idx_q [LV+1][P];
  logic [DW-1:0] dat_q [LV+1][P];

  // Level zero samples the cells; each further level halves the node count,
  // the left child winning so that the first hit in list order survives.
  always_ff @(posedge clk) begin
    for (int i = 0; i < P; i++) begin
      if (i < N) begin
        hit_q[0][i] <= hit[i];
        dat_q[0][i] <= data[i];
      end else begin
        hit_q[0][i] <= 1'b0;
        dat_q[0][i] <= '0;
      end
      idx_q[0][i] <= LV'(i);
    end
    for (int l = 1; l <= LV; l++) begin
      for (int i = 0; i < P; i++) begin
        if (i < (P >> l)) begin
          hit_q[l][i] <= hit_q[l-1][2*i] | hit_q[l-1][2*i+1];
          if (hit_q[l-1][2*i]) begin
            idx_q[l][i] <= idx_q[l-1][2*i];
            dat_q[l][i] <= dat_q[l-1][2*i];
          end else begin
            idx_q[l][i] <= idx_q[l-1][2*i+1];
            dat_q[l][i] <= dat_q[l-1][2*i+1];
          end
        end else begin
          hit_q[l][i] <= 1'b0;
          idx_q[l][i] <= '0;
          dat_q[l][i] <= '0;
        end
      end
    end
  end

  assign root_hit  = hit_q[LV][0];
  assign root_idx  = idx_q[LV][0];
  assign root_data = dat_q[LV][0];

endmodule

[rtl/core/positional_list_engine.sv]
// Top level of the positional list engine: a chain of slot cells, a lookup tree and control.
//
// The engine keeps an ordered list of up to DEPTH entries, one per cell of a
// chain, with a fill count. A request word asks to insert a value at a 1-based
// position, erase the entry at a position, get the entry at a position, or
// find the first entry equal to a value. Each request gives exactly one
// response word carrying a status, an item, the find position and the fill
// count after the request. Failed requests leave the list untouched and
// return whatever entry 0 holds. Requests are handled one at a time: each
// passes through acceptance, a lookup while the registered priority tree
// collects the hit flags of all cells, and the final, completing state in
// which the status is decided, the chain shifts in a single step and the
// response is registered.
// A new request is accepted while the previous response still waits to be
// taken; the engine only holds in its final cycle if that response is still
// outstanding. Reset clears every entry and the fill count at once.
module positional_list_engine #(
  parameter int unsigned DEPTH     = 64,
  parameter int unsigned ITEM_BITS = 32
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            req_valid,
  output logic            req_ready,
  input  ple_pkg::req_t   req,
  output logic            rsp_valid,
  input  logic            rsp_ready,
  output ple_pkg::rsp_t   rsp
);
  import ple_pkg::*;

  // Fill count width, compare width with headroom, tree depth and latency.
  localparam int unsigned FW   = $clog2(DEPTH + 1);
  localparam int unsigned CW   = ((FW > POS_W) ? FW : POS_W) + 1;
  localparam int unsigned LV   = $clog2(DEPTH);
  localparam int unsigned LAT  = LV + 1;
  localparam int unsigned CNTW = $clog2(LAT + 1);

  state_t               state;
  state_t               state_next;
  logic [CNTW-1:0]      cnt;
  req_t                 req_q;
  logic [FW-1:0]        fill;
  logic [FW-1:0]        fill_next;

  logic [ITEM_BITS-1:0] ent [DEPTH];
  logic                 hit [DEPTH];
  cell_ctl_t            ctl;
  logic [CW-1:0]        pm1;
  logic [CW-1:0]        pos_w;
  logic [CW-1:0]        fill_w;
  logic [ITEM_BITS-1:0] key;

  logic                 root_hit;
  logic [LV-1:0]        root_idx;
  logic [ITEM_BITS-1:0] root_data;

  logic                 is_full;
  logic                 ins_bad;
  logic                 pos_bad;
  logic                 go;
  cell_op_t             res_op;
  rsp_t                 res;

  // Request decoding shared by the cells and the decision logic.
  assign key    = ITEM_BITS'(req_q.value);
  assign pos_w  = CW'(req_q.position);
  assign fill_w = CW'(fill);
  assign pm1    = pos_w - CW'(1);

  assign is_full = (fill_w == CW'(DEPTH));
  assign ins_bad = (req_q.position == '0) || (pos_w > (fill_w + CW'(1)));
  assign pos_bad = (req_q.position == '0) || (pos_w > fill_w);

  // The final cycle completes once the response register is free.
  assign go = (state == S_DONE) && (!rsp_valid || rsp_ready);

  // The chain only moves in the completing cycle, so the tree sees stable
  // entries throughout the lookup.
  assign ctl.op   = go ? res_op : CO_HOLD;
  assign ctl.find = (req_q.kind == K_FIND);

  // Chain of slot cells; each passes its entry to the neighbours it has.
  for (genvar k = 0; k < DEPTH; k++) begin : g_cell
    logic [ITEM_BITS-1:0] left_d;
    logic [ITEM_BITS-1:0] right_d;

    if (k == 0) begin : g_first
      assign left_d = '0;
    end else begin : g_inner_l
      assign left_d = ent[k-1];
    end

    if (k == DEPTH - 1) begin : g_last
      assign right_d = '0;
    end else begin : g_inner_r
      assign right_d = ent[k+1];
    end

    ple_cell #(
      .IDX       (k),
      .ITEM_BITS (ITEM_BITS),
      .CW        (CW)
    ) u_cell (
      .clk    (clk),
      .rst    (rst),
      .ctl    (ctl),
      .pm1    (pm1),
      .fill_w (fill_w),
      .key    (key),
      .left   (left_d),
      .right  (right_d),
      .entry  (ent[k]),
      .hit    (hit[k])
    );
  end

  ple_tree #(
    .N  (DEPTH),
    .DW (ITEM_BITS)
  ) u_tree (
    .clk       (clk),
    .hit       (hit),
    .data      (ent),
    .root_hit  (root_hit),
    .root_idx  (root_idx),
    .root_data (root_data)
  );

  // Decision: status, item and the change to the list. Failures report
  // entry 0 as it stands and leave everything unchanged.
  always_comb begin
    res.status   = ST_OK;
    res.item     = VAL_W'(ent[0]);
    res.found_at = '0;
    res_op       = CO_HOLD;
    fill_next    = fill;
    case (req_q.kind)
      K_INSERT: begin
        if (is_full) begin
          res.status = ST_FULL;
        end else if (ins_bad) begin
          res.status = ST_RANGE;
        end else begin
          res.item  = VAL_W'(key);
          res_op    = CO_INSERT;
          fill_next = fill + FW'(1);
        end
      end
      K_ERASE: begin
        if (pos_bad) begin
          res.status = ST_RANGE;
        end else begin
          res.item  = VAL_W'(root_data);
          res_op    = CO_ERASE;
          fill_next = fill - FW'(1);
        end
      end
      K_GET: begin
        if (pos_bad) begin
          res.status = ST_RANGE;
        end else begin
          res.item = VAL_W'(root_data);
        end
      end
      default: begin
        if (root_hit) begin
          res.item     = VAL_W'(root_data);
          res.found_at = POS_W'(CW'(root_idx) + CW'(1));
        end else begin
          res.status = ST_MISS;
        end
      end
    endcase
    res.count = POS_W'(fill_next);
  end

  // Control sequence: next state.
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (req_valid) begin
          state_next = S_LOOK;
        end
      end
      S_LOOK: begin
        if (cnt == CNTW'(LAT - 1)) begin
          state_next = S_DONE;
        end
      end
      S_DONE: begin
        if (go) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  // Control sequence: outputs.
  always_comb begin
    req_ready = 1'b0;
    unique case (state)
      S_IDLE:  req_ready = 1'b1;
      S_LOOK:  req_ready = 1'b0;
      S_DONE:  req_ready = 1'b0;
      default: req_ready = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      cnt       <= '0;
      fill      <= '0;
      rsp_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (state == S_IDLE) begin
        cnt <= '0;
      end else if (state == S_LOOK) begin
        cnt <= cnt + CNTW'(1);
      end
      if (go) begin
        fill      <= fill_next;
        rsp_valid <= 1'b1;
      end else if (rsp_ready) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  // Request and response words carry no reset.
  always_ff @(posedge clk) begin
    if (req_valid && req_ready) begin
      req_q <= req;
    end
    if (go) begin
      rsp <= res;
    end
  end

  // A successful insert grows the list by exactly one entry.
  a_insert_grows: assert property (@(posedge clk) disable iff (rst)
    (go && req_q.kind == K_INSERT && res.status == ST_OK)
      |=> (fill == FW'($past(fill) + FW'(1))))
    else $error("fill did not grow after a successful insert");

  // A successful erase shrinks the list by exactly one entry.
  a_erase_shrinks: assert property (@(posedge clk) disable iff (rst)
    (go && req_q.kind == K_ERASE && res.status == ST_OK)
      |=> (fill == FW'($past(fill) - FW'(1))))
    else $error("fill did not shrink after a successful erase");

  // A find can only match a live entry.
  a_find_live: assert property (@(posedge clk) disable iff (rst)
    (state == S_DONE && req_q.kind == K_FIND && root_hit)
      |-> (CW'(root_idx) < fill_w))
    else $error("find matched beyond the end of the list");

  // A response only appears after a completing cycle.
  a_rsp_origin: assert property (@(posedge clk) disable iff (rst)
    $rose(rsp_valid) |-> ($past(state) == S_DONE))
    else $error("response raised outside the completing cycle");

endmodule
